/* sv/lpg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared widths, register indexes, reset values and helpers for the laser
// pulse-per-distance gate.
// ----------------------------------------------------------------------------
package lpg_pkg;

   // item fields
   localparam int DELTA_W   = 24;
   localparam int REQ_DATA_W = 2 * DELTA_W;
   localparam int RSP_DATA_W = 8;

   // configuration registers
   localparam int PPS_W      = 20;
   localparam int PLEN_W     = 16;
   localparam int THR_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PULSES_PER_STEP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_LENGTH_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_THRESHOLD_SQ  = 2'd2;

   localparam logic [PPS_W-1:0]  PPS_RESET  = 20'd0;
   localparam logic [PLEN_W-1:0] PLEN_RESET = 16'd11;
   localparam logic [THR_W-1:0]  THR_RESET  = 32'd1;

   // counters
   localparam int ON_W    = 17;
   localparam int SINCE_W = 31;
   localparam logic [ON_W-1:0]    ON_MAX    = {ON_W{1'b1}};
   localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};

   // arithmetic widths
   localparam int D2_W   = 2 * DELTA_W;         // dx^2 + dy^2
   localparam int EP_W   = SINCE_W + PPS_W;     // elapsed * pulses_per_step
   localparam int ASQ_W  = 25;                  // a below 2^25 gets squared
   localparam int A2_W   = 2 * ASQ_W;
   localparam int FIN_W  = D2_W + A2_W;
   localparam int FIRE_SHIFT = 48;
   localparam logic [FIN_W-1:0] FIRE_LIMIT = FIN_W'(1) << FIRE_SHIFT;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SQ   = 5'b00010,
      ST_ASQ  = 5'b00100,
      ST_FIN  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   // magnitude of a two's complement delta; the most negative value maps to 2^23
   function automatic logic [DELTA_W-1:0] mag_delta(input logic [DELTA_W-1:0] v);
      logic [DELTA_W-1:0] neg;
      neg = ~v + DELTA_W'(1);
      return v[DELTA_W-1] ? neg : v;
   endfunction

endpackage
`default_nettype wire

/* sv/lpg_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_mul
// Sequential radix-4 shift-add multiplier: two multiplier bits per cycle, the
// low product bits shift out into the multiplier register.
// ----------------------------------------------------------------------------
module lpg_mul #(
   parameter int MCAND_W = 24,
   parameter int MPLR_W  = 24
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [MCAND_W-1:0]         mcand,
   input  wire logic [MPLR_W-1:0]          mplr,
   output logic                            busy,
   output logic [MCAND_W+MPLR_W-1:0]       product
);
   localparam int DIGITS = (MPLR_W + 1) / 2;
   localparam int LO_W   = 2 * DIGITS;
   localparam int HI_W   = MCAND_W + 2;
   localparam int CNT_W  = $clog2(DIGITS + 1);

   logic [MCAND_W-1:0] mcand_ff, mcand_in;
   logic [HI_W-1:0]    hi_ff, hi_in;
   logic [LO_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               busy_ff, busy_in;

   logic [HI_W-1:0]    pp;
   logic [HI_W-1:0]    sum;
   logic [MCAND_W+LO_W-1:0] full;

   // hi stays at or below mcand, so hi + 3*mcand fits in HI_W bits
   assign pp  = ({2'b00, mcand_ff} & {HI_W{lo_ff[0]}})
              + ({1'b0, mcand_ff, 1'b0} & {HI_W{lo_ff[1]}});
   assign sum = hi_ff + pp;

   always_comb begin
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = LO_W'(mplr);
         count_in = CNT_W'(DIGITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in    = sum >> 2;
         lo_in    = {sum[1:0], lo_ff[LO_W-1:2]};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign full    = {hi_ff[MCAND_W-1:0], lo_ff};
   assign product = full[MCAND_W+MPLR_W-1:0];
   assign busy    = busy_ff;

endmodule
`default_nettype wire

/* sv/laser_pulse_per_distance_gate_top.sv */
`default_nettype none
// Timing: an accepted req item passes the two-bit-per-step multiplier chain:
//   the squares and E*P, then (E*P)^2, then the final product, then rsp_tvalid.
// Flow: one item at a time, no new item is taken until the last one commits;
//   req_tready is high while idle, also while a result waits in the output register.
// Reset (synchronous, active high): laser off, counters zero, registers to
//   their reset values.
// ----------------------------------------------------------------------------
// laser_pulse_per_distance_gate_top
// Per servo tick laser gate: follows the arm input, or fires pulses spaced by
// travelled distance using an exact squared comparison.
// ----------------------------------------------------------------------------
module laser_pulse_per_distance_gate_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: delta_x [23:0], delta_y [47:24]
   input  wire logic [lpg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: armed [0]
   input  wire logic                              req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // rsp_tdata: laser_on [0], zero [7:1]
   output logic [lpg_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [lpg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lpg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lpg_pkg::*;

   state_type state_ff, state_in;

   logic [PPS_W-1:0]   pps_ff;
   logic [PLEN_W-1:0]  plen_ff;
   logic [THR_W-1:0]   thr_ff;

   logic               level_ff, level_in;
   logic [ON_W-1:0]    on_ff, on_in;
   logic [SINCE_W-1:0] since_ff, since_in;

   logic               armed_ff;
   logic [D2_W-1:0]    d2_ff;
   logic               a_big_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_laser_ff;

   logic               req_acc;
   logic [DELTA_W-1:0] mag_x, mag_y;
   logic [SINCE_W-1:0] since_inc;
   logic [ON_W-1:0]    on_inc;

   logic               sqx_busy, sqy_busy, ep_busy, asq_busy, fin_busy;
   logic [D2_W-1:0]    sqx_prod, sqy_prod;
   logic [EP_W-1:0]    ep_prod;
   logic [A2_W-1:0]    asq_prod;
   logic [FIN_W-1:0]   fin_prod;
   logic               asq_start, fin_start, commit;
   logic               stopped, fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign mag_x = mag_delta(req_tdata[DELTA_W-1:0]);
   assign mag_y = mag_delta(req_tdata[REQ_DATA_W-1:DELTA_W]);

   // counters advance from the state left by the previous item
   assign since_inc = (since_ff == SINCE_MAX) ? since_ff : since_ff + SINCE_W'(1);
   assign on_inc    = (level_ff && on_ff != ON_MAX) ? on_ff + ON_W'(1) : on_ff;

   lpg_mul #(.MCAND_W(DELTA_W), .MPLR_W(DELTA_W)) u_sqx (
      .clock(clock), .reset(reset), .start(req_acc),
      .mcand(mag_x), .mplr(mag_x), .busy(sqx_busy), .product(sqx_prod)
   );

   lpg_mul #(.MCAND_W(DELTA_W), .MPLR_W(DELTA_W)) u_sqy (
      .clock(clock), .reset(reset), .start(req_acc),
      .mcand(mag_y), .mplr(mag_y), .busy(sqy_busy), .product(sqy_prod)
   );

   lpg_mul #(.MCAND_W(SINCE_W), .MPLR_W(PPS_W)) u_ep (
      .clock(clock), .reset(reset), .start(req_acc),
      .mcand(since_inc), .mplr(pps_ff), .busy(ep_busy), .product(ep_prod)
   );

   assign asq_start = (state_ff == ST_SQ) && !sqx_busy && !sqy_busy && !ep_busy;

   lpg_mul #(.MCAND_W(ASQ_W), .MPLR_W(ASQ_W)) u_asq (
      .clock(clock), .reset(reset), .start(asq_start),
      .mcand(ep_prod[ASQ_W-1:0]), .mplr(ep_prod[ASQ_W-1:0]),
      .busy(asq_busy), .product(asq_prod)
   );

   assign fin_start = (state_ff == ST_ASQ) && !asq_busy;

   lpg_mul #(.MCAND_W(D2_W), .MPLR_W(A2_W)) u_fin (
      .clock(clock), .reset(reset), .start(fin_start),
      .mcand(d2_ff), .mplr(asq_prod), .busy(fin_busy), .product(fin_prod)
   );

   assign commit = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   // E*P >= 2^25 squares past 2^48, so any nonzero distance fires
   assign stopped = d2_ff < D2_W'(thr_ff);
   assign fire    = a_big_ff ? (d2_ff != '0) : (fin_prod > FIRE_LIMIT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_acc) state_in = ST_SQ;
         ST_SQ:   if (asq_start) state_in = ST_ASQ;
         ST_ASQ:  if (fin_start) state_in = ST_FIN;
         ST_FIN:  if (!fin_busy) state_in = ST_OUT;
         ST_OUT:  if (commit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      level_in = level_ff;
      on_in    = on_ff;
      since_in = since_ff;
      if (commit) begin
         if (pps_ff == '0) begin
            level_in = armed_ff;
         end else if (!armed_ff) begin
            level_in = 1'b0;
         end else if (stopped) begin
            level_in = 1'b0;
            on_in    = '0;
            since_in = '0;
         end else if (level_ff) begin
            since_in = since_inc;
            if (on_inc > ON_W'(plen_ff)) begin
               level_in = 1'b0;
               on_in    = '0;
            end else begin
               on_in = on_inc;
            end
         end else if (fire) begin
            level_in = 1'b1;
            on_in    = '0;
            since_in = '0;
         end else begin
            on_in    = on_inc;
            since_in = since_inc;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= 1'b0;
         on_ff        <= '0;
         since_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         on_ff        <= on_in;
         since_ff     <= since_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pps_ff  <= PPS_RESET;
         plen_ff <= PLEN_RESET;
         thr_ff  <= THR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PULSES_PER_STEP:    pps_ff  <= csr_wdata[PPS_W-1:0];
            CSR_PULSE_LENGTH_TICKS: plen_ff <= csr_wdata[PLEN_W-1:0];
            CSR_STOP_THRESHOLD_SQ:  thr_ff  <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         armed_ff <= req_tuser;
      end
      if (asq_start) begin
         d2_ff    <= sqx_prod + sqy_prod;
         a_big_ff <= (ep_prod[EP_W-1:ASQ_W] != '0);
      end
      if (commit) begin
         rsp_laser_ff <= level_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, rsp_laser_ff};

endmodule
`default_nettype wire
